[hdl/assert_macros.svh]
// Assertion helpers for the framebuffer line engine checker.
// Both expect signals named clock and reset in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MFLE_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mfle_checker: same-cycle implication failed");

// Next-cycle implication.
`define MFLE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mfle_checker: next-cycle implication failed");

`endif

[hdl/mfle_pkg.sv]
`default_nettype none

package mfle_pkg;

   localparam logic [2:0] CMD_PIXEL  = 3'd0;
   localparam logic [2:0] CMD_LINE   = 3'd1;
   localparam logic [2:0] CMD_FILL   = 3'd2;
   localparam logic [2:0] CMD_SCROLL = 3'd3;
   localparam logic [2:0] CMD_READ   = 3'd4;

   localparam logic [7:0] PIXEL_ON   = 8'hFF;
   localparam logic [7:0] BYTE_CLEAR = 8'h00;

   // Bresenham error term: covers -255..255 with margin
   localparam int ERR_W = 10;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] x_start;
      logic [7:0] y_start;
      logic [7:0] x_end;
      logic [7:0] y_end;
      logic [7:0] value;
      logic [9:0] byte_index;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       off_screen;
   } rsp_beat_type;

   typedef struct packed {
      logic [7:0] x;
      logic [7:0] y;
   } point_type;

   typedef struct packed {
      logic [7:0] x_start;
      logic [7:0] y_start;
      logic [7:0] x_end;
      logic [7:0] y_end;
   } line_type;

endpackage

`default_nettype wire

[hdl/mono_framebuffer_line_engine_core.sv]
`default_nettype none

// Page-packed monochrome framebuffer with pixel, line, fill, scroll-left and
// byte-read commands; one result beat per command, taken one command at a
// time (req_stall is high from acceptance until the result is handed to the
// output register). All work goes through one single-port-write,
// registered-read byte RAM of SCREEN_WIDTH*ceil(SCREEN_HEIGHT/8) bytes
// (B, 1024 by default), so the time a command takes follows its RAM
// accesses: pixel and line read and write one byte per plotted point, fill
// writes all B bytes, scroll left reads and writes each byte in turn. After
// reset a clearing pass writes zero to all B bytes before the first
// command is taken. The result register frees the engine to accept the next
// command while a result waits on rsp_stall.
module mono_framebuffer_line_engine_core
   import mfle_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_beat_type req_beat,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_beat_type      rsp_beat
);

   localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
   localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
   localparam int AW          = $clog2(STORE_BYTES);
   localparam int CW          = $clog2(SCREEN_WIDTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(SCREEN_WIDTH - 1);

   typedef enum logic [8:0] {
      ST_INIT    = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_FILL    = 9'b000000100,
      ST_SCR_RD  = 9'b000001000,
      ST_SCR_WR  = 9'b000010000,
      ST_DRAW_RD = 9'b000100000,
      ST_DRAW_WR = 9'b001000000,
      ST_READ    = 9'b010000000,
      ST_DONE    = 9'b100000000
   } state_type;

   state_type    state_ff, state_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] col_ff, col_in;
   logic [7:0]   value_ff, value_in;
   rsp_beat_type res_ff, res_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_beat_ff;
   logic         rsp_load;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;

   logic          walk_start, walk_step, walk_last;
   line_type      walk_line;
   point_type     walk_pt;

   logic [AW-1:0] draw_addr;
   logic [7:0]    draw_mask;
   logic          pix_off;
   logic          idx_ok;

   mfle_ram #(
      .DEPTH (STORE_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mfle_line_walker #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_walker (
      .clock   (clock),
      .start   (walk_start),
      .step    (walk_step),
      .line_in (walk_line),
      .point   (walk_pt),
      .last    (walk_last)
   );

   // a pixel is drawn as a one-point line
   always_comb begin
      walk_line.x_start = req_beat.x_start;
      walk_line.y_start = req_beat.y_start;
      walk_line.x_end   = (req_beat.cmd == CMD_LINE) ? req_beat.x_end : req_beat.x_start;
      walk_line.y_end   = (req_beat.cmd == CMD_LINE) ? req_beat.y_end : req_beat.y_start;
   end

   assign pix_off   = (int'(req_beat.x_start) >= SCREEN_WIDTH) ||
                      (int'(req_beat.y_start) >= SCREEN_HEIGHT);
   assign idx_ok    = int'(req_beat.byte_index) < STORE_BYTES;
   assign draw_addr = AW'(int'(walk_pt.x) + int'(walk_pt.y[7:3]) * SCREEN_WIDTH);
   assign draw_mask = 8'd1 << walk_pt.y[2:0];

   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      col_in     = col_ff;
      value_in   = value_ff;
      res_in     = res_ff;
      wr_en      = 1'b0;
      wr_addr    = addr_ff;
      wr_data    = value_ff;
      rd_en      = 1'b0;
      rd_addr    = addr_ff;
      walk_start = 1'b0;
      walk_step  = 1'b0;
      rsp_load   = 1'b0;

      case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_data = BYTE_CLEAR;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               addr_in  = '0;
               col_in   = '0;
               value_in = req_beat.value;
               case (req_beat.cmd)
                  CMD_PIXEL: begin
                     if (pix_off) begin
                        res_in.off_screen = 1'b1;
                        state_in          = ST_DONE;
                     end else begin
                        walk_start = 1'b1;
                        state_in   = ST_DRAW_RD;
                     end
                  end
                  CMD_LINE: begin
                     walk_start = 1'b1;
                     state_in   = ST_DRAW_RD;
                  end
                  CMD_FILL:   state_in = ST_FILL;
                  CMD_SCROLL: state_in = ST_SCR_RD;
                  CMD_READ: begin
                     if (idx_ok) begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_beat.byte_index);
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_FILL: begin
            wr_en = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DONE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_SCR_RD: begin
            // the right neighbor; the last column takes zero instead
            rd_en    = col_ff != LAST_COL;
            rd_addr  = addr_ff + AW'(1);
            state_in = ST_SCR_WR;
         end
         ST_SCR_WR: begin
            wr_en   = 1'b1;
            wr_data = (col_ff == LAST_COL) ? BYTE_CLEAR : rd_data;
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DONE;
            end else begin
               addr_in  = addr_ff + AW'(1);
               col_in   = (col_ff == LAST_COL) ? '0 : (col_ff + CW'(1));
               state_in = ST_SCR_RD;
            end
         end
         ST_DRAW_RD: begin
            rd_en    = 1'b1;
            rd_addr  = draw_addr;
            state_in = ST_DRAW_WR;
         end
         ST_DRAW_WR: begin
            wr_en   = 1'b1;
            wr_addr = draw_addr;
            wr_data = (value_ff == PIXEL_ON) ? (rd_data | draw_mask) : (rd_data & ~draw_mask);
            if (walk_last) begin
               state_in = ST_DONE;
            end else begin
               walk_step = 1'b1;
               state_in  = ST_DRAW_RD;
            end
         end
         ST_READ: begin
            res_in.read_data = rd_data;
            state_in         = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      res_ff   <= res_in;
      if (rsp_load) begin
         rsp_beat_ff <= res_ff;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

`default_nettype wire

[hdl/mfle_ram.sv]
`default_nettype none

module mfle_ram
   import mfle_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/mfle_line_walker.sv]
`default_nettype none

module mfle_line_walker
   import mfle_pkg::*;
#(
   parameter int SCREEN_WIDTH  = 128,
   parameter int SCREEN_HEIGHT = 64
) (
   input  wire logic     clock,
   input  wire logic     start,
   input  wire logic     step,
   input  wire line_type line_in,
   output point_type     point,
   output logic          last
);

   localparam logic [7:0] X_MAX = 8'(SCREEN_WIDTH - 1);
   localparam logic [7:0] Y_MAX = 8'(SCREEN_HEIGHT - 1);

   logic [7:0] x_ff, y_ff, xb_ff, yb_ff, dx_ff, dy_ff;
   logic       sx_ff, sy_ff;
   logic signed [ERR_W-1:0] err_ff;

   logic [7:0] xa_c, ya_c, xb_c, yb_c, dx_c, dy_c;
   logic signed [ERR_W-1:0] err0_c, dx_s, dy_s, dx_term, dy_term, err_in;
   logic step_x, step_y;

   // clamp endpoints and set up the walk
   always_comb begin
      xa_c = (line_in.x_start > X_MAX) ? X_MAX : line_in.x_start;
      ya_c = (line_in.y_start > Y_MAX) ? Y_MAX : line_in.y_start;
      xb_c = (line_in.x_end   > X_MAX) ? X_MAX : line_in.x_end;
      yb_c = (line_in.y_end   > Y_MAX) ? Y_MAX : line_in.y_end;
      dx_c = (xa_c < xb_c) ? (xb_c - xa_c) : (xa_c - xb_c);
      dy_c = (ya_c < yb_c) ? (yb_c - ya_c) : (ya_c - yb_c);
      if (dx_c > dy_c) begin
         err0_c = $signed(ERR_W'(dx_c >> 1));
      end else begin
         err0_c = -$signed(ERR_W'(dy_c >> 1));
      end
   end

   // one Bresenham step
   always_comb begin
      dx_s    = $signed(ERR_W'(dx_ff));
      dy_s    = $signed(ERR_W'(dy_ff));
      step_x  = err_ff > -dx_s;
      step_y  = err_ff < dy_s;
      dy_term = step_x ? dy_s : $signed(ERR_W'(0));
      dx_term = step_y ? dx_s : $signed(ERR_W'(0));
      err_in  = err_ff - dy_term + dx_term;
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= xa_c;
         y_ff   <= ya_c;
         xb_ff  <= xb_c;
         yb_ff  <= yb_c;
         dx_ff  <= dx_c;
         dy_ff  <= dy_c;
         sx_ff  <= xa_c < xb_c;
         sy_ff  <= ya_c < yb_c;
         err_ff <= err0_c;
      end else if (step) begin
         err_ff <= err_in;
         if (step_x) begin
            x_ff <= sx_ff ? (x_ff + 8'd1) : (x_ff - 8'd1);
         end
         if (step_y) begin
            y_ff <= sy_ff ? (y_ff + 8'd1) : (y_ff - 8'd1);
         end
      end
   end

   assign point = '{x: x_ff, y: y_ff};
   assign last  = (x_ff == xb_ff) && (y_ff == yb_ff);

endmodule

`default_nettype wire

[hdl/mfle_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module mfle_checker
   import mfle_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_beat_type req_beat,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_beat_type rsp_beat
);

   // stalled result beat holds
   `MFLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_beat))

   // one command at a time: an accepted beat closes the request side
   `MFLE_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // a result only shows up while a command was in flight
   `MFLE_ASSERT_IMPL(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall))

   // read data and off-screen flag come from different commands
   `MFLE_ASSERT_IMPL(a_rsp_fields, rsp_valid && rsp_beat.off_screen,
                     rsp_beat.read_data == 8'h00)

endmodule

bind mono_framebuffer_line_engine_core mfle_checker u_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
   import mfle_pkg::*;

   localparam int SCREEN_W    = 128;
   localparam int SCREEN_H    = 64;
   localparam int PAGES       = (SCREEN_H + 7) / 8;
   localparam int STORE_BYTES = SCREEN_W * PAGES;

   // codes the block treats as no-ops
   localparam logic [2:0] CMD_RSVD_A = 3'd5;
   localparam logic [2:0] CMD_RSVD_C = 3'd7;

   // scroll left is the slowest command
   localparam int SLOWEST_CMD  = 2 * STORE_BYTES + 2;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 4 * (SLOWEST_CMD + STORE_BYTES + HOLD_CYCLES + 100);
   localparam int SETTLE_WAIT  = SLOWEST_CMD + 50;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_beat_type req_beat;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_beat_type rsp_beat;

   logic [7:0]   frame_model [STORE_BYTES];
   rsp_beat_type pending_results [$];
   int           fail_count  = 0;
   int           hold_cycles = 0;
   int           stall_run   = 0;
   bit           req_gaps_on = 1'b0;
   bit           rsp_gaps_on = 1'b0;
   int           recent_addr = 0;

   mono_framebuffer_line_engine_core #(
      .SCREEN_WIDTH (SCREEN_W),
      .SCREEN_HEIGHT(SCREEN_H)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_beat (req_beat),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_beat (rsp_beat)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------- framebuffer predictor ----------------

   function automatic bit model_plot(int x, int y, logic [7:0] v);
      int addr;
      if (x >= SCREEN_W || y >= SCREEN_H) return 1'b1;
      addr = x + (y / 8) * SCREEN_W;
      if (addr >= STORE_BYTES) return 1'b1;
      frame_model[addr][y % 8] = (v == PIXEL_ON);
      return 1'b0;
   endfunction

   function automatic void model_line(int xa, int ya, int xb, int yb, logic [7:0] v);
      int dx, dy, sx, sy, err, e2, lo, hi;
      if (xa > SCREEN_W - 1) xa = SCREEN_W - 1;
      if (xb > SCREEN_W - 1) xb = SCREEN_W - 1;
      if (ya > SCREEN_H - 1) ya = SCREEN_H - 1;
      if (yb > SCREEN_H - 1) yb = SCREEN_H - 1;
      dx  = (xa < xb) ? xb - xa : xa - xb;
      dy  = (ya < yb) ? yb - ya : ya - yb;
      sx  = (xa < xb) ? 1 : -1;
      sy  = (ya < yb) ? 1 : -1;
      err = ((dx > dy) ? dx : -dy) / 2;   // truncates toward zero
      if (dx == 0) begin
         lo = (ya < yb) ? ya : yb;
         hi = (ya < yb) ? yb : ya;
         for (int i = lo; i <= hi; i++) void'(model_plot(xa, i, v));
         return;
      end
      if (dy == 0) begin
         lo = (xa < xb) ? xa : xb;
         hi = (xa < xb) ? xb : xa;
         for (int i = lo; i <= hi; i++) void'(model_plot(i, ya, v));
         return;
      end
      for (int g = 0; g < 1024; g++) begin
         void'(model_plot(xa, ya, v));
         if (xa == xb && ya == yb) break;
         e2 = err;
         if (e2 > -dx) begin
            err -= dy;
            xa  += sx;
         end
         if (e2 < dy) begin
            err += dx;
            ya  += sy;
         end
      end
   endfunction

   function automatic void model_scroll();
      int base;
      for (int p = 0; p < PAGES; p++) begin
         base = p * SCREEN_W;
         for (int c = 0; c + 1 < SCREEN_W; c++) frame_model[base + c] = frame_model[base + c + 1];
         frame_model[base + SCREEN_W - 1] = BYTE_CLEAR;
      end
   endfunction

   function automatic rsp_beat_type run_command(req_beat_type b);
      rsp_beat_type r;
      r = '0;
      case (b.cmd)
         CMD_PIXEL:  r.off_screen = model_plot(b.x_start, b.y_start, b.value);
         CMD_LINE:   model_line(b.x_start, b.y_start, b.x_end, b.y_end, b.value);
         CMD_FILL:   foreach (frame_model[i]) frame_model[i] = b.value;
         CMD_SCROLL: model_scroll();
         CMD_READ: begin
            if (b.byte_index < STORE_BYTES) r.read_data = frame_model[b.byte_index];
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------- request side ----------------

   function automatic int pick_gap();
      int r;
      if (!req_gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_cmd(req_beat_type b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_beat  <= b;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(run_command(b));
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic req_beat_type make_cmd(logic [2:0] cmd, int xs, int ys, int xe, int ye,
                                             int v, int idx);
      req_beat_type b;
      b.cmd        = cmd;
      b.x_start    = 8'(xs);
      b.y_start    = 8'(ys);
      b.x_end      = 8'(xe);
      b.y_end      = 8'(ye);
      b.value      = 8'(v);
      b.byte_index = 10'(idx);
      return b;
   endfunction

   function automatic int rand_coord(int span);
      // mostly on screen, sometimes anywhere in the field range
      return ($urandom_range(0, 99) < 85) ? $urandom_range(0, span - 1) : $urandom_range(0, 255);
   endfunction

   function automatic req_beat_type random_cmd();
      req_beat_type b;
      logic [63:0]  raw;
      int r;
      raw = {$urandom, $urandom};
      b   = raw[$bits(req_beat_type)-1:0];
      r   = $urandom_range(0, 99);
      if (r < 30) begin
         b.cmd     = CMD_PIXEL;
         b.x_start = 8'(rand_coord(SCREEN_W));
         b.y_start = 8'(rand_coord(SCREEN_H));
         if ($urandom_range(0, 99) < 60) b.value = PIXEL_ON;
         if (b.x_start < SCREEN_W && b.y_start < SCREEN_H)
            recent_addr = b.x_start + (b.y_start / 8) * SCREEN_W;
      end else if (r < 55) begin
         b.cmd     = CMD_LINE;
         b.x_start = 8'(rand_coord(SCREEN_W));
         b.y_start = 8'(rand_coord(SCREEN_H));
         case ($urandom_range(0, 3))
            0: b.x_end = b.x_start;
            1: b.y_end = b.y_start;
            default: begin
               b.x_end = 8'(rand_coord(SCREEN_W));
               b.y_end = 8'(rand_coord(SCREEN_H));
            end
         endcase
         if ($urandom_range(0, 99) < 70) b.value = PIXEL_ON;
         recent_addr = ((b.x_start < SCREEN_W) ? b.x_start : SCREEN_W - 1)
                     + (((b.y_start < SCREEN_H) ? b.y_start : SCREEN_H - 1) / 8) * SCREEN_W;
      end else if (r < 88) begin
         b.cmd = CMD_READ;
         if ($urandom_range(0, 1)) b.byte_index = 10'(recent_addr);
      end else if (r < 92) begin
         b.cmd = CMD_FILL;
         case ($urandom_range(0, 3))
            0: b.value = BYTE_CLEAR;
            1: b.value = PIXEL_ON;
            default: ;
         endcase
      end else if (r < 96) begin
         b.cmd = CMD_SCROLL;
      end else begin
         b.cmd = 3'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
      end
      return b;
   endfunction

   // ---------------- result side ----------------

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall   <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else if (stall_run > 0) begin
         rsp_stall <= 1'b1;
         stall_run <= stall_run - 1;
      end else if (rsp_gaps_on && $urandom_range(0, 99) < 30) begin
         rsp_stall <= 1'b1;
         stall_run <= ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                   : $urandom_range(15, 50);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("result beat with no command outstanding: read_data %0h off_screen %0b",
                   rsp_beat.read_data, rsp_beat.off_screen);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_beat.read_data !== want.read_data) begin
               $error("read_data mismatch: expected %0h, actual %0h",
                      want.read_data, rsp_beat.read_data);
               fail_count++;
            end
            if (rsp_beat.off_screen !== want.off_screen) begin
               $error("off_screen mismatch: expected %0b, actual %0b",
                      want.off_screen, rsp_beat.off_screen);
               fail_count++;
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // ---------------- tests ----------------

   task automatic test_reset_state();
      send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(CMD_READ, 255, 255, 255, 255, 255, STORE_BYTES - 1));
   endtask

   task automatic test_pixel_cmds();
      send_cmd(make_cmd(CMD_PIXEL, 0, 0, 0, 0, PIXEL_ON, 0));
      send_cmd(make_cmd(CMD_PIXEL, SCREEN_W - 1, SCREEN_H - 1, 0, 0, PIXEL_ON, 0));
      send_cmd(make_cmd(CMD_PIXEL, 255, 255, 255, 255, PIXEL_ON, 1023));
      send_cmd(make_cmd(CMD_PIXEL, SCREEN_W, 5, 0, 0, PIXEL_ON, 0));
      send_cmd(make_cmd(CMD_PIXEL, 3, SCREEN_H, 0, 0, PIXEL_ON, 0));
      // anything but all-ones clears
      send_cmd(make_cmd(CMD_PIXEL, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 8'hFE, 0));
      send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, STORE_BYTES - 1));
   endtask

   task automatic test_line_cmds();
      send_cmd(make_cmd(CMD_LINE, 5, 2, 5, 60, PIXEL_ON, 0));
      send_cmd(make_cmd(CMD_LINE, 120, 10, 7, 10, PIXEL_ON, 0));
      send_cmd(make_cmd(CMD_LINE, 0, 0, SCREEN_W - 1, 40, PIXEL_ON, 0));
      send_cmd(make_cmd(CMD_LINE, 90, SCREEN_H - 1, 80, 1, BYTE_CLEAR, 0));
      // both endpoints clamp: becomes a full diagonal
      send_cmd(make_cmd(CMD_LINE, 255, 0, 0, 255, PIXEL_ON, 0));
      send_cmd(make_cmd(CMD_LINE, 9, 9, 9, 9, PIXEL_ON, 0));
      send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 5 + 2 * SCREEN_W));
   endtask

   task automatic test_fill_scroll();
      send_cmd(make_cmd(CMD_FILL, 0, 0, 0, 0, 8'hA5, 0));
      send_cmd(make_cmd(CMD_PIXEL, SCREEN_W - 1, 0, 0, 0, BYTE_CLEAR, 0));
      send_cmd(make_cmd(CMD_SCROLL, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, SCREEN_W - 2));
      send_cmd(make_cmd(CMD_READ, 0, 0, 0, 0, 0, SCREEN_W - 1));
      for (int c = CMD_RSVD_A; c <= CMD_RSVD_C; c++)
         send_cmd(make_cmd(3'(c), 255, 255, 255, 255, 255, 1023));
   endtask

   task automatic test_random_mix(int segments, int per_segment);
      for (int s = 0; s < segments; s++) begin
         // cycle through back-to-back traffic, gaps on the result side only, and gaps on both sides
         req_gaps_on = s[0];
         rsp_gaps_on = s[0] | s[1];
         repeat (per_segment) send_cmd(random_cmd());
      end
   endtask

   task automatic test_output_backpressure();
      req_gaps_on = 1'b0;
      hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 12; i++)
         send_cmd((i % 2) ? make_cmd(CMD_READ, 0, 0, 0, 0, 0, recent_addr) : random_cmd());
   endtask

   task automatic test_pause_and_resume();
      wait_drain();
      repeat (20) @(negedge clock);
      req_gaps_on = 1'b1;
      repeat (14) send_cmd(random_cmd());
   endtask

   initial begin
      foreach (frame_model[i]) frame_model[i] = BYTE_CLEAR;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_beat  = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_state();
      test_pixel_cmds();
      test_line_cmds();
      test_fill_scroll();
      test_random_mix(8, 50);
      test_output_backpressure();
      test_pause_and_resume();

      wait_drain();
      rsp_gaps_on = 1'b0;
      repeat (SETTLE_WAIT) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/mfle_pkg.sv
hdl/mfle_ram.sv
hdl/mfle_line_walker.sv
hdl/mono_framebuffer_line_engine_core.sv
hdl/mfle_checker.sv
tb/tb_top.sv
